/* design/ura_pkg.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging averager package
// Shared widths, register codes and the per-tick step record.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int READING_W  = 13;
  localparam int INTERVAL_W = 20;
  localparam int TIMEOUT_W  = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

  localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
  localparam logic [CH_W-1:0] CH_RIGHT  = 2'd1;
  localparam logic [CH_W-1:0] CH_MIDDLE = 2'd2;

  typedef struct packed {
    logic [NUM_CH-1:0]    trig;
    logic                 sample;
    logic [CH_W-1:0]      ch;
    logic                 tmo;
    logic [READING_W-1:0] reading;
  } step_t;

endpackage

/* design/ura_seq.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer
// Interval counter, trigger and echo timing machine, configuration registers.
// ----------------------------------------------------------------------------
module ura_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic [ura_pkg::NUM_CH-1:0]       echo,
  input  logic                             cfg_valid,
  input  logic [ura_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [ura_pkg::CH_W-1:0]         cur_ch,
  output ura_pkg::step_t                   step
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT} phase_t;

  localparam int TW = ura_pkg::TIMEOUT_W;
  localparam int IW = ura_pkg::INTERVAL_W;
  localparam logic [TW-1:0] TRIG_LOW_TICKS  = 15'd2;
  localparam logic [TW-1:0] TRIG_HIGH_TICKS = 15'd10;
  localparam logic [ura_pkg::READING_W:0] READING_MAX = 14'd8191;

  function automatic logic [ura_pkg::CH_W-1:0] chan_of(input logic [ura_pkg::CH_W-1:0] c);
    chan_of = (c >= ura_pkg::CH_MIDDLE) ? ura_pkg::CH_MIDDLE : c;
  endfunction

  logic [IW-1:0]             interval_r;
  logic [TW-1:0]             timeout_r;
  logic [IW-1:0]             ic_r, ic_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [TW-1:0]             pc_r, pc_nxt;
  logic [ura_pkg::CH_W-1:0]  ac_r, ac_nxt;
  logic                      started_r, started_nxt;
  logic [TW-1:0]             ew_r, ew_nxt;
  logic [IW:0]               ic_inc;
  logic [TW-1:0]             pc_inc;
  logic                      echo_sel;
  logic                      done;
  logic [TW-1:0]             width;
  logic [23:0]               scaled;
  logic [ura_pkg::READING_W:0] reading_raw;

  assign cur_ch   = chan_of(ac_r);
  assign echo_sel = echo[cur_ch];
  assign ic_inc   = {1'b0, ic_r} + 21'd1;
  assign ic_nxt   = (ic_inc >= {1'b0, interval_r}) ? '0 : ic_inc[IW-1:0];
  assign scaled   = {9'd0, width} * 24'd279;
  assign reading_raw = scaled[23:10];

  always_comb begin
    phase_nxt   = phase_r;
    pc_nxt      = pc_r;
    ac_nxt      = ac_r;
    started_nxt = started_r;
    ew_nxt      = ew_r;
    done        = 1'b0;
    width       = '0;
    step.tmo    = 1'b0;
    pc_inc      = pc_r + 15'd1;
    unique case (phase_r)
      PH_IDLE: begin
        if (ic_r == '0) begin
          phase_nxt = PH_TRIG_LOW;
          pc_nxt    = '0;
        end
      end
      PH_TRIG_LOW: begin
        pc_nxt = pc_inc;
        if (pc_inc >= TRIG_LOW_TICKS) begin
          phase_nxt = PH_TRIG_HIGH;
          pc_nxt    = '0;
        end
      end
      PH_TRIG_HIGH: begin
        pc_nxt = pc_inc;
        if (pc_inc >= TRIG_HIGH_TICKS) begin
          phase_nxt   = PH_WAIT;
          pc_nxt      = '0;
          started_nxt = 1'b0;
          ew_nxt      = '0;
        end
      end
      PH_WAIT: begin
        pc_nxt = (pc_r != '1) ? pc_inc : pc_r;
        if (echo_sel) begin
          started_nxt = 1'b1;
          ew_nxt      = (ew_r != '1) ? ew_r + 15'd1 : ew_r;
        end else if (started_r) begin
          done  = 1'b1;
          width = ew_r;
        end
        if (!done && pc_nxt >= timeout_r) begin
          done     = 1'b1;
          width    = '0;
          step.tmo = 1'b1;
        end
        if (done) begin
          ac_nxt      = (ac_r >= ura_pkg::CH_MIDDLE) ? ura_pkg::CH_LEFT : ac_r + 2'd1;
          phase_nxt   = PH_IDLE;
          pc_nxt      = '0;
          started_nxt = 1'b0;
          ew_nxt      = '0;
        end
      end
    endcase
    step.sample  = done;
    step.ch      = done ? cur_ch : ura_pkg::CH_LEFT;
    step.reading = (reading_raw > READING_MAX) ? READING_MAX[ura_pkg::READING_W-1:0]
                                               : reading_raw[ura_pkg::READING_W-1:0];
    for (int k = 0; k < ura_pkg::NUM_CH; k++) begin
      step.trig[k] = (phase_nxt == PH_TRIG_HIGH) && (chan_of(ac_nxt) == k[ura_pkg::CH_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 20'd10000;
      timeout_r  <= 15'd6000;
      ic_r       <= '0;
      phase_r    <= PH_IDLE;
      pc_r       <= '0;
      ac_r       <= ura_pkg::CH_LEFT;
      started_r  <= 1'b0;
      ew_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ura_pkg::REG_INTERVAL: interval_r <= cfg_data[IW-1:0];
          ura_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data[TW-1:0];
        endcase
      end
      if (step_en) begin
        ic_r      <= ic_nxt;
        phase_r   <= phase_nxt;
        pc_r      <= pc_nxt;
        ac_r      <= ac_nxt;
        started_r <= started_nxt;
        ew_r      <= ew_nxt;
      end
    end
  end

  a_echo_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> phase_r == PH_WAIT) else $error("echo start flag outside wait");
  a_trig_not_with_sample: assert property (@(posedge clk) disable iff (!rst_n)
    step.sample |-> step.trig == '0) else $error("trigger raised on a completing tick");
  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ac_r != 2'd3) else $error("active channel code three");

endmodule

/* design/ura_ring.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging reading rings
// One ring of readings per channel in a shared memory, with running sums.
// ----------------------------------------------------------------------------
module ura_ring #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step_en,
  input  ura_pkg::step_t                       step,
  input  logic [ura_pkg::CH_W-1:0]             cur_ch,
  output logic [ura_pkg::NUM_CH-1:0][ura_pkg::READING_W+$clog2(AVG_DEPTH)-1:0] sums
);

  localparam int IDX_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = ura_pkg::READING_W + IDX_W;
  localparam int ADDR_W = ura_pkg::CH_W + IDX_W;
  localparam int MEM_DEPTH = ura_pkg::NUM_CH * (2 ** IDX_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

  logic [ura_pkg::READING_W-1:0] mem [MEM_DEPTH];
  logic [ura_pkg::READING_W-1:0] rd_r;
  logic [IDX_W-1:0]              widx_r [ura_pkg::NUM_CH];
  logic [ura_pkg::NUM_CH-1:0]    full_r;
  logic [SUM_W-1:0]              sum_r  [ura_pkg::NUM_CH];
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ura_pkg::READING_W-1:0] old_val;
  logic [SUM_W-1:0]              sum_nxt;
  logic                          wr;

  assign wr      = step_en && step.sample;
  assign rd_addr = {cur_ch, widx_r[cur_ch]};
  assign wr_addr = {step.ch, widx_r[step.ch]};
  assign old_val = full_r[step.ch] ? rd_r : '0;
  assign sum_nxt = sum_r[step.ch] - SUM_W'(old_val) + SUM_W'(step.reading);

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (wr) begin
      mem[wr_addr] <= step.reading;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      for (int c = 0; c < ura_pkg::NUM_CH; c++) begin
        widx_r[c] <= '0;
        sum_r[c]  <= '0;
      end
    end else if (wr) begin
      sum_r[step.ch] <= sum_nxt;
      if (widx_r[step.ch] == IDX_LAST) begin
        widx_r[step.ch] <= '0;
        full_r[step.ch] <= 1'b1;
      end else begin
        widx_r[step.ch] <= widx_r[step.ch] + 1'b1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < ura_pkg::NUM_CH; c++) begin
      sums[c] = sum_r[c];
    end
  end

  a_store_same_channel: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> step.ch == cur_ch) else $error("stored channel differs from read channel");
  a_read_address_settled: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> $stable(rd_addr)) else $error("ring read address changed before store");
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r[cur_ch] <= IDX_LAST) else $error("ring write index out of range");

endmodule

/* design/ura_mean.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging ring mean
// Ring sum divided by the ring depth by reciprocal multiply, plus one centimetre.
// ----------------------------------------------------------------------------
module ura_mean #(
  parameter int AVG_DEPTH = 8
) (
  input  logic [ura_pkg::READING_W+$clog2(AVG_DEPTH)-1:0] sum,
  output logic [ura_pkg::READING_W-1:0]                   avg
);

  localparam int IDX_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = ura_pkg::READING_W + IDX_W;
  localparam int SH = SUM_W + IDX_W;
  localparam longint unsigned RECIP = ((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [SH-1:0] RECIP_C = RECIP[SH-1:0];
  localparam int PW = SUM_W + SH;
  localparam logic [ura_pkg::READING_W:0] OFFSET = 14'd16;
  localparam logic [ura_pkg::READING_W:0] AVG_MAX = 14'd8191;

  logic [PW-1:0]               prod;
  logic [ura_pkg::READING_W:0] quot;
  logic [ura_pkg::READING_W:0] biased;

  assign prod   = PW'(sum) * PW'(RECIP_C);
  assign quot   = prod[SH +: ura_pkg::READING_W + 1];
  assign biased = quot + OFFSET;
  assign avg    = (biased > AVG_MAX) ? AVG_MAX[ura_pkg::READING_W-1:0]
                                     : biased[ura_pkg::READING_W-1:0];

endmodule

/* design/ultrasonic_ranging_averager.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging averager
// Three-sensor echo ranging with a moving average of readings per sensor.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel is one microsecond tick carrying the three
// echo levels. For every tick taken, exactly one transfer leaves on the out_
// channel with the trigger levels, the three ring means in sixteenths of a
// centimetre plus one centimetre, and in tuser whether a reading was stored,
// its channel and whether it came from a timeout.
// A tick passes an input register, the sequencer and ring update into a step
// register, and the reciprocal multiply for the means into the output
// register. One tick is taken every cycle while out_tready keeps the output
// moving; the figure is set by the sequencer step and the one-write-per-cycle
// ring memory.
// When out_tready is low the output register holds its transfer and the
// stages behind it fill; in_tready falls once all three are occupied.
// Reset clears the counters, the sequencer, the ring sums and the ring fill
// flags, so all means read one centimetre; configuration returns to an
// interval of 10000 ticks and a timeout of 6000 ticks. cfg_ready is always
// high; write only while no tick is in flight.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_averager #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // echo_left, echo_right, echo_middle
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,  // trig_left, trig_right, trig_middle,
                                                       // avg_left, avg_right, avg_middle
  output logic [3:0]                       out_tuser,  // new_sample, sample_channel, timed_out
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ura_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ura_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = ura_pkg::READING_W + $clog2(AVG_DEPTH);

  logic                                             a_valid_r;
  logic [ura_pkg::NUM_CH-1:0]                       a_echo_r;
  logic                                             b_valid_r;
  ura_pkg::step_t                                   b_step_r;
  logic                                             out_valid_r;
  logic [47:0]                                      out_data_r;
  logic [3:0]                                       out_user_r;
  logic                                             out_ok, b_adv, b_ok, a_adv, a_ok;
  ura_pkg::step_t                                   step;
  logic [ura_pkg::CH_W-1:0]                         cur_ch;
  logic [ura_pkg::NUM_CH-1:0][SUM_W-1:0]            sums;
  logic [ura_pkg::NUM_CH-1:0][ura_pkg::READING_W-1:0] avgs;

  assign out_ok    = !out_valid_r || out_tready;
  assign b_adv     = b_valid_r && out_ok;
  assign b_ok      = !b_valid_r || b_adv;
  assign a_adv     = a_valid_r && b_ok;
  assign a_ok      = !a_valid_r || a_adv;
  assign in_tready = a_ok;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  ura_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (a_adv),
    .echo      (a_echo_r),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cur_ch    (cur_ch),
    .step      (step)
  );

  ura_ring #(.AVG_DEPTH(AVG_DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (a_adv),
    .step    (step),
    .cur_ch  (cur_ch),
    .sums    (sums)
  );

  for (genvar g = 0; g < ura_pkg::NUM_CH; g++) begin : g_mean
    ura_mean #(.AVG_DEPTH(AVG_DEPTH)) u_mean (
      .sum (sums[g]),
      .avg (avgs[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ok) begin
        a_valid_r <= in_tvalid;
      end
      if (b_ok) begin
        b_valid_r <= a_adv;
      end
      if (out_ok) begin
        out_valid_r <= b_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && a_ok) begin
      a_echo_r <= in_tdata[ura_pkg::NUM_CH-1:0];
    end
    if (a_adv) begin
      b_step_r <= step;
    end
    if (b_adv) begin
      out_data_r <= {6'd0, avgs[2], avgs[1], avgs[0], b_step_r.trig};
      out_user_r <= {b_step_r.tmo, b_step_r.ch, b_step_r.sample};
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
  a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_data_r[2:0])) else $error("more than one trigger high");
  a_quiet_tuser: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r[0] |-> out_user_r[3:1] == 3'd0)
    else $error("sample fields set without a sample");
  a_floor_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[15:3] >= 13'd16 && out_data_r[28:16] >= 13'd16
                    && out_data_r[41:29] >= 13'd16) else $error("mean below offset");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Ultrasonic ranging averager testbench
// Streams echo ticks through the block and checks every output tick against a
// tick-accurate predictor of the sensor sequencer and the per-sensor rings.
// Echo pulses are shaped to the predicted listening window, so most
// measurements finish cleanly; timeouts, noise and register extremes are mixed
// in, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 8;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int SCALE_MUL  = 279;
  localparam int SCALE_SHR  = 10;
  localparam int READING_MAX = 8191;
  localparam int MEAN_OFFSET = 16;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_TRIG_LOW, SEQ_TRIG_HIGH, SEQ_LISTEN} seq_phase_t;
  typedef enum logic [1:0] {PULSE_CLEAN, PULSE_SILENT, PULSE_NOISE} pulse_kind_t;

  typedef struct packed {
    logic [ura_pkg::NUM_CH-1:0]                         trig;
    logic [ura_pkg::NUM_CH-1:0][ura_pkg::READING_W-1:0] avg;
    logic                                               sample;
    logic [ura_pkg::CH_W-1:0]                           ch;
    logic                                               tmo;
  } tick_result_t;

  class echo_ranging_model;
    logic [ura_pkg::INTERVAL_W-1:0] interval_cfg;
    logic [ura_pkg::TIMEOUT_W-1:0]  timeout_cfg;
    logic [ura_pkg::INTERVAL_W-1:0] interval_cnt;
    seq_phase_t                     phase;
    logic [ura_pkg::TIMEOUT_W-1:0]  phase_cnt;
    logic [ura_pkg::CH_W-1:0]       active_ch;
    logic                           echo_seen;
    logic [ura_pkg::TIMEOUT_W-1:0]  echo_len;
    logic [ura_pkg::READING_W-1:0]  ring [ura_pkg::NUM_CH][RING_DEPTH];
    logic [SLOT_W-1:0]              wr_slot [ura_pkg::NUM_CH];
    logic [15:0]                    ring_total [ura_pkg::NUM_CH];
    int unsigned                    stored [ura_pkg::NUM_CH];
    tick_result_t                   pending_ticks [$];
    int unsigned                    errors;
    int unsigned                    checked;
    string                          side [ura_pkg::NUM_CH] = '{"left", "right", "middle"};

    function new();
      interval_cfg = 20'd10000;
      timeout_cfg  = 15'd6000;
      interval_cnt = '0;
      phase        = SEQ_IDLE;
      phase_cnt    = '0;
      active_ch    = ura_pkg::CH_LEFT;
      echo_seen    = 1'b0;
      echo_len     = '0;
      errors       = 0;
      checked      = 0;
      for (int c = 0; c < ura_pkg::NUM_CH; c++) begin
        for (int s = 0; s < RING_DEPTH; s++) ring[c][s] = '0;
        wr_slot[c]    = '0;
        ring_total[c] = '0;
        stored[c]     = 0;
      end
    endfunction

    function void write_reg(logic [ura_pkg::CFG_IDX_W-1:0] idx,
                            logic [ura_pkg::CFG_DATA_W-1:0] value);
      if (idx == ura_pkg::REG_INTERVAL) interval_cfg = value;
      else if (idx == ura_pkg::REG_TIMEOUT) timeout_cfg = value[ura_pkg::TIMEOUT_W-1:0];
    endfunction

    function logic [ura_pkg::CH_W-1:0] active_sensor();
      return (active_ch >= ura_pkg::CH_MIDDLE) ? ura_pkg::CH_MIDDLE : active_ch;
    endfunction

    function void take_tick(logic [ura_pkg::NUM_CH-1:0] echo);
      tick_result_t r;
      bit           due;
      bit           done;
      int unsigned  nxt;
      int unsigned  reading;
      int unsigned  mean;
      logic [ura_pkg::CH_W-1:0] ch;
      r   = '0;
      due = (interval_cnt == '0);
      nxt = interval_cnt + 1;
      ch  = active_sensor();
      interval_cnt = (nxt >= interval_cfg) ? '0 : nxt[ura_pkg::INTERVAL_W-1:0];
      case (phase)
        SEQ_IDLE: begin
          if (due) begin
            phase     = SEQ_TRIG_LOW;
            phase_cnt = '0;
          end
        end
        SEQ_TRIG_LOW: begin
          phase_cnt++;
          if (phase_cnt >= 2) begin
            phase     = SEQ_TRIG_HIGH;
            phase_cnt = '0;
          end
        end
        SEQ_TRIG_HIGH: begin
          phase_cnt++;
          if (phase_cnt >= 10) begin
            phase     = SEQ_LISTEN;
            phase_cnt = '0;
            echo_seen = 1'b0;
            echo_len  = '0;
          end
        end
        default: begin
          done    = 1'b0;
          reading = 0;
          if (phase_cnt != '1) phase_cnt++;
          if (echo[ch]) begin
            echo_seen = 1'b1;
            if (echo_len != '1) echo_len++;
          end else if (echo_seen) begin
            done    = 1'b1;
            reading = echo_len;
          end
          if (!done && phase_cnt >= timeout_cfg) begin
            done    = 1'b1;
            reading = 0;
            r.tmo   = 1'b1;
          end
          if (done) begin
            reading = (reading * SCALE_MUL) >> SCALE_SHR;
            if (reading > READING_MAX) reading = READING_MAX;
            ring_total[ch] = ring_total[ch] - ring[ch][wr_slot[ch]]
                             + reading[ura_pkg::READING_W-1:0];
            ring[ch][wr_slot[ch]] = reading[ura_pkg::READING_W-1:0];
            wr_slot[ch] = (wr_slot[ch] == RING_DEPTH - 1) ? '0 : wr_slot[ch] + 1'b1;
            stored[ch]++;
            r.sample  = 1'b1;
            r.ch      = ch;
            active_ch = (active_ch >= ura_pkg::CH_MIDDLE) ? ura_pkg::CH_LEFT
                                                          : active_ch + 1'b1;
            phase     = SEQ_IDLE;
            phase_cnt = '0;
            echo_seen = 1'b0;
            echo_len  = '0;
          end
        end
      endcase
      for (int k = 0; k < ura_pkg::NUM_CH; k++) begin
        r.trig[k] = (phase == SEQ_TRIG_HIGH) && (active_sensor() == k);
        mean = ring_total[k] / RING_DEPTH + MEAN_OFFSET;
        if (mean > READING_MAX) mean = READING_MAX;
        r.avg[k] = mean[ura_pkg::READING_W-1:0];
      end
      pending_ticks.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_tick(logic [47:0] tdata, logic [3:0] tuser);
      tick_result_t want;
      logic [ura_pkg::READING_W-1:0] got_avg;
      if (pending_ticks.size() == 0) begin
        report($sformatf("output transfer with nothing expected, tdata %h tuser %h",
                         tdata, tuser));
        return;
      end
      want = pending_ticks.pop_front();
      for (int k = 0; k < ura_pkg::NUM_CH; k++) begin
        if (tdata[k] !== want.trig[k])
          report($sformatf("tick %0d trig_%s got %b expected %b",
                           checked, side[k], tdata[k], want.trig[k]));
        got_avg = tdata[ura_pkg::NUM_CH + k*ura_pkg::READING_W +: ura_pkg::READING_W];
        if (got_avg !== want.avg[k])
          report($sformatf("tick %0d avg_%s got %0d expected %0d",
                           checked, side[k], got_avg, want.avg[k]));
      end
      if (tdata[47:ura_pkg::NUM_CH*(1+ura_pkg::READING_W)] !== '0)
        report($sformatf("tick %0d tdata padding not zero: %h", checked, tdata));
      if (tuser[0] !== want.sample)
        report($sformatf("tick %0d new_sample got %b expected %b",
                         checked, tuser[0], want.sample));
      if (tuser[2:1] !== want.ch)
        report($sformatf("tick %0d sample_channel got %0d expected %0d",
                         checked, tuser[2:1], want.ch));
      if (tuser[3] !== want.tmo)
        report($sformatf("tick %0d timed_out got %b expected %b",
                         checked, tuser[3], want.tmo));
      checked++;
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // echo_left, echo_right, echo_middle
  logic                           out_tvalid;
  logic                           out_tready;
  logic [47:0]                    out_tdata;  // trig_left, trig_right, trig_middle,
                                              // avg_left, avg_right, avg_middle
  logic [3:0]                     out_tuser;  // new_sample, sample_channel, timed_out
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ura_pkg::CFG_DATA_W-1:0] cfg_data;

  echo_ranging_model sb;

  bit          rush;
  int          in_run, out_run;
  bit          in_quiet, out_quiet;
  bit          planned;
  pulse_kind_t pulse_kind;
  int          pulse_pos, pulse_delay, pulse_width;

  ultrasonic_ranging_averager #(.AVG_DEPTH(RING_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait(inout int run_left, inout bit quiet);
    if (rush) return 0;
    if (run_left == 0) begin
      run_left = $urandom_range(8, 48);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Shapes the active sensor's echo around the predicted listening window.
  function automatic logic [ura_pkg::NUM_CH-1:0] next_echo(input int wmax, input int dmax,
                                                           input bit long_left);
    logic [ura_pkg::NUM_CH-1:0] echo;
    logic [ura_pkg::CH_W-1:0]   ch;
    int                         roll;
    echo = ura_pkg::NUM_CH'($urandom);
    if (sb.phase != SEQ_LISTEN) begin
      planned = 1'b0;
      return echo;
    end
    ch = sb.active_sensor();
    if (!planned) begin
      planned     = 1'b1;
      pulse_pos   = 0;
      pulse_delay = $urandom_range(0, dmax);
      pulse_width = $urandom_range(1, wmax);
      if (long_left) begin
        pulse_kind = PULSE_CLEAN;
        if (ch == ura_pkg::CH_LEFT) begin
          pulse_delay = $urandom_range(0, 3);
          pulse_width = $urandom_range(30070, 30700);
        end else begin
          pulse_delay = $urandom_range(0, 2);
          pulse_width = $urandom_range(1, 3);
        end
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 7) pulse_kind = PULSE_CLEAN;
        else if (roll < 8 && sb.timeout_cfg <= 400) pulse_kind = PULSE_SILENT;
        else pulse_kind = PULSE_NOISE;
      end
    end
    case (pulse_kind)
      PULSE_CLEAN:  echo[ch] = (pulse_pos >= pulse_delay) &&
                               (pulse_pos < pulse_delay + pulse_width);
      PULSE_SILENT: echo[ch] = 1'b0;
      default: ;
    endcase
    pulse_pos++;
    return echo;
  endfunction

  task automatic send_tick(input logic [ura_pkg::NUM_CH-1:0] echo);
    int gap;
    gap = draw_wait(in_run, in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {{(8-ura_pkg::NUM_CH){1'b0}}, echo};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_tick(echo);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [ura_pkg::INTERVAL_W-1:0] interval,
                              input logic [ura_pkg::TIMEOUT_W-1:0] timeout);
    cfg_valid <= 1'b1;
    cfg_index <= ura_pkg::REG_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(ura_pkg::REG_INTERVAL, interval);
    @(negedge clk);
    cfg_index <= ura_pkg::REG_TIMEOUT;
    cfg_data  <= ura_pkg::CFG_DATA_W'(timeout);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(ura_pkg::REG_TIMEOUT, ura_pkg::CFG_DATA_W'(timeout));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending_ticks.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input bit write, input logic [ura_pkg::INTERVAL_W-1:0] interval,
                           input logic [ura_pkg::TIMEOUT_W-1:0] timeout, input int ticks,
                           input int wmax, input int dmax, input bit long_left);
    int sent;
    int unsigned goal;
    settle();
    if (write) program_regs(interval, timeout);
    goal = sb.stored[ura_pkg::CH_LEFT] + (long_left ? RING_DEPTH + 1 : 0);
    rush = long_left;
    sent = 0;
    while (sent < ticks || sb.stored[ura_pkg::CH_LEFT] < goal) begin
      send_tick(next_echo(wmax, dmax, long_left));
      sent++;
    end
    in_tvalid <= 1'b0;
    rush = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_tick(out_tdata, out_tuser);
  end

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(out_run, out_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [ura_pkg::INTERVAL_W-1:0] iv;
    logic [ura_pkg::TIMEOUT_W-1:0]  tm;
    sb        = new();
    rush      = 1'b0;
    planned   = 1'b0;
    in_run    = 0;
    out_run   = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = ura_pkg::REG_INTERVAL;
    cfg_data  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then the register extremes.
    run_phase(1'b0, 20'd0, 15'd0, 40, 4, 2, 1'b0);
    run_phase(1'b1, 20'd0, 15'd0, 40, 4, 2, 1'b0);
    run_phase(1'b1, 20'd1, 15'd1, 40, 4, 2, 1'b0);
    run_phase(1'b1, 20'd2, 15'd5, 60, 8, 2, 1'b0);
    run_phase(1'b1, 20'd64, 15'h7FFF, 40, 200, 12, 1'b0);
    run_phase(1'b1, 20'hFFFFF, 15'd30000, 30, 4, 2, 1'b0);

    repeat (8) begin
      case ($urandom_range(0, 4))
        0:       iv = 20'd0;
        1:       iv = 20'd1;
        2:       iv = 20'($urandom_range(2, 30));
        3:       iv = 20'($urandom_range(31, 100));
        default: iv = 20'($urandom_range(101, 300));
      endcase
      case ($urandom_range(0, 4))
        0:       tm = 15'd0;
        1:       tm = 15'd1;
        2:       tm = 15'($urandom_range(2, 40));
        3:       tm = 15'($urandom_range(41, 400));
        default: tm = 15'd30000;
      endcase
      run_phase(1'b1, iv, tm, 50, $urandom_range(1, 200), $urandom_range(0, 12), 1'b0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
